// ----- sv/ddlc_pkg.sv -----
// Shared types, constants and codes of the dashed DDA line stepper.
package ddlc_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS = 16;
	localparam int SCR_BITS = 11;
	localparam int POS_BITS = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS = FRAC_BITS + 2;
	localparam int QUO_BITS = FRAC_BITS + 1;
	localparam int REM_BITS = COORD_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);
	localparam int SUM_BITS = ((COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS) + 2;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X_MIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X_MAX = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y_MIN = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y_MAX = 3'd5;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic                         op;
		logic signed [COORD_BITS-1:0] x_start;
		logic signed [COORD_BITS-1:0] y_start;
		logic signed [COORD_BITS-1:0] x_end;
		logic signed [COORD_BITS-1:0] y_end;
	} in_t;

	typedef struct packed {
		logic                pixel_valid;
		logic [SCR_BITS-1:0] pixel_x;
		logic [SCR_BITS-1:0] pixel_y;
		logic                done_res;
	} out_t;

	typedef struct packed {
		logic [SCR_BITS-1:0] origin_x;
		logic [SCR_BITS-1:0] origin_y;
		logic [SCR_BITS-1:0] clip_x_min;
		logic [SCR_BITS-1:0] clip_x_max;
		logic [SCR_BITS-1:0] clip_y_min;
		logic [SCR_BITS-1:0] clip_y_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		origin_x:   11'd500,
		origin_y:   11'd375,
		clip_x_min: 11'd10,
		clip_x_max: 11'd500,
		clip_y_min: 11'd10,
		clip_y_max: 11'd740
	};

	typedef struct packed {
		logic                  start;
		logic [COORD_BITS-1:0] dividend;
		logic [COORD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_TICK
	} state_t;

endpackage

// ----- sv/ddlc_div.sv -----
// Restoring serial divider giving (dividend * 2^FRAC_BITS) / divisor, one quotient bit a cycle.
module ddlc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ddlc_pkg::div_req_t                 req,
	output ddlc_pkg::div_stat_t                stat,
	output logic [ddlc_pkg::QUO_BITS-1:0]      quotient
);

	logic [ddlc_pkg::REM_BITS-1:0]     rem_q;
	logic [ddlc_pkg::COORD_BITS-1:0]   den_q;
	logic [ddlc_pkg::QUO_BITS-1:0]     quo_q;
	logic [ddlc_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic                              first_q;
	logic                              busy_q;
	logic                              done_q;

	logic [ddlc_pkg::REM_BITS-1:0] trial;
	logic [ddlc_pkg::REM_BITS-1:0] den_ext;
	logic                          ge;

	// The dividend never exceeds the divisor, so the first step compares it unshifted
	// and yields the integer bit of the quotient.
	always_comb begin
		trial = first_q ? rem_q : {rem_q[ddlc_pkg::REM_BITS-2:0], 1'b0};
		den_ext = {1'b0, den_q};
		ge = (trial >= den_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			first_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				cnt_q <= ddlc_pkg::DIV_CNT_BITS'(ddlc_pkg::FRAC_BITS);
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - den_ext) : trial;
			quo_q <= {quo_q[ddlc_pkg::QUO_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/ddlc_map.sv -----
// Truncation of the fixed-point position, screen mapping and clip window test.
module ddlc_map (
	input  logic signed [ddlc_pkg::POS_BITS-1:0] pos_x,
	input  logic signed [ddlc_pkg::POS_BITS-1:0] pos_y,
	input  logic                                 odd_step,
	input  logic                                 last_step,
	input  ddlc_pkg::cfg_t                       cfg,
	output ddlc_pkg::out_t                       result
);

	localparam int C = ddlc_pkg::COORD_BITS;
	localparam int F = ddlc_pkg::FRAC_BITS;
	localparam int S = ddlc_pkg::SUM_BITS;
	localparam int W = ddlc_pkg::SCR_BITS;

	logic signed [C-1:0] wx;
	logic signed [C-1:0] wy;
	logic signed [S-1:0] sx;
	logic signed [S-1:0] sy;
	logic signed [S-1:0] ox;
	logic signed [S-1:0] oy;
	logic                in_win;

	// Truncation toward zero: a negative value with a non-zero fraction rounds up by one.
	always_comb begin
		wx = pos_x[ddlc_pkg::POS_BITS-1:F]
			+ C'(pos_x[ddlc_pkg::POS_BITS-1] && (pos_x[F-1:0] != '0));
		wy = pos_y[ddlc_pkg::POS_BITS-1:F]
			+ C'(pos_y[ddlc_pkg::POS_BITS-1] && (pos_y[F-1:0] != '0));
		ox = $signed({{(S-W){1'b0}}, cfg.origin_x});
		oy = $signed({{(S-W){1'b0}}, cfg.origin_y});
		sx = ox + $signed({{(S-C){wx[C-1]}}, wx});
		sy = oy - $signed({{(S-C){wy[C-1]}}, wy});
		in_win = (sx >= $signed({{(S-W){1'b0}}, cfg.clip_x_min}))
			&& (sx <= $signed({{(S-W){1'b0}}, cfg.clip_x_max}))
			&& (sy >= $signed({{(S-W){1'b0}}, cfg.clip_y_min}))
			&& (sy <= $signed({{(S-W){1'b0}}, cfg.clip_y_max}));
		result.pixel_valid = odd_step && in_win;
		result.pixel_x = result.pixel_valid ? sx[W-1:0] : '0;
		result.pixel_y = result.pixel_valid ? sy[W-1:0] : '0;
		result.done_res = last_step;
	end

endmodule

// ----- sv/dashed_dda_line_clipped_core.sv -----
// Top level of the dashed DDA line stepper: sequencer, segment state and result register.
//
// Usage. Items arrive on in_valid/in_data and are taken at an edge where in_stall is low.
// A start transaction (op 0) loads a segment and gives no result; a tick transaction (op 1)
// gives exactly one result on out_valid/out_data, taken at an edge where out_stall is low.
// Start: with a non-zero length, both increments come from one serial divider that yields
// one quotient bit a cycle, run for x and then for y, so in_stall stays high after the
// start is taken until both divisions finish. A zero-length start leaves the sequencer idle.
// Tick on an active segment: the position add happens at the accepting edge, mapping and
// clipping at the next, so the result is registered in the cycle after acceptance and the next
// item can be taken once the sequencer is back in idle. A tick with no segment gives its
// result at the accepting edge, so such ticks can follow each other while out_stall is low.
// A finished result waits in the output register; while the receiver stalls it and it is
// still full, in_stall stays high, since each tick needs a free result slot.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken (cfg_ready is high)
// and are meant for idle periods. Indexes beyond 5 are ignored.
// Reset (arst_n low) clears the segment, empties the output register and restores the
// register defaults; no clearing pass is needed.
module dashed_dda_line_clipped_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ddlc_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ddlc_pkg::out_t                       out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ddlc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ddlc_pkg::SCR_BITS-1:0]        cfg_data
);

	localparam int C = ddlc_pkg::COORD_BITS;
	localparam int F = ddlc_pkg::FRAC_BITS;
	localparam int P = ddlc_pkg::POS_BITS;
	localparam int I = ddlc_pkg::INC_BITS;
	localparam int Q = ddlc_pkg::QUO_BITS;

	ddlc_pkg::state_t state_q;
	ddlc_pkg::state_t state_d;
	ddlc_pkg::cfg_t   cfg_q;

	logic signed [P-1:0] pos_x_q;
	logic signed [P-1:0] pos_y_q;
	logic signed [I-1:0] inc_x_q;
	logic signed [I-1:0] inc_y_q;
	logic [C-1:0]        step_total_q;
	logic [C-1:0]        step_number_q;
	logic                active_q;
	logic [C-1:0]        ady_q;
	logic                neg_x_q;
	logic                neg_y_q;
	logic                out_valid_q;
	ddlc_pkg::out_t      out_q;

	logic signed [C:0]   dx;
	logic signed [C:0]   dy;
	logic [C:0]          adx_w;
	logic [C:0]          ady_w;
	logic [C-1:0]        adx;
	logic [C-1:0]        ady;
	logic [C-1:0]        steps;

	logic                accept;
	logic                acc_start;
	logic                acc_tick;
	logic                load_seg;
	logic                ld_inc_x;
	logic                ld_inc_y;
	logic                adv_pos;
	logic                wr_idle_res;
	logic                wr_tick_res;
	logic [C-1:0]        step_next;
	logic                last_step;
	logic [Q-1:0]        quotient;
	logic signed [I-1:0] quo_pos;
	logic signed [I-1:0] quo_neg;

	ddlc_pkg::div_req_t  div_req;
	ddlc_pkg::div_stat_t div_stat;
	ddlc_pkg::out_t      tick_res;

	// Segment geometry straight from the start transaction.
	always_comb begin
		dx = $signed({in_data.x_end[C-1], in_data.x_end})
			- $signed({in_data.x_start[C-1], in_data.x_start});
		dy = $signed({in_data.y_end[C-1], in_data.y_end})
			- $signed({in_data.y_start[C-1], in_data.y_start});
		adx_w = dx[C] ? -dx : dx;
		ady_w = dy[C] ? -dy : dy;
		adx = adx_w[C-1:0];
		ady = ady_w[C-1:0];
		steps = (adx > ady) ? adx : ady;
	end

	assign accept = in_valid && !in_stall;
	assign acc_start = accept && (in_data.op == ddlc_pkg::OP_START);
	assign acc_tick = accept && (in_data.op == ddlc_pkg::OP_TICK);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ddlc_pkg::ST_IDLE: begin
				if (acc_start && (steps != '0)) begin
					state_d = ddlc_pkg::ST_DIV_X;
				end else if (acc_tick && active_q) begin
					state_d = ddlc_pkg::ST_TICK;
				end
			end
			ddlc_pkg::ST_DIV_X: begin
				if (div_stat.done) begin
					state_d = ddlc_pkg::ST_DIV_Y;
				end
			end
			ddlc_pkg::ST_DIV_Y: begin
				if (div_stat.done) begin
					state_d = ddlc_pkg::ST_IDLE;
				end
			end
			ddlc_pkg::ST_TICK: begin
				state_d = ddlc_pkg::ST_IDLE;
			end
			default: begin
				state_d = ddlc_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = 1'b1;
		load_seg = 1'b0;
		ld_inc_x = 1'b0;
		ld_inc_y = 1'b0;
		adv_pos = 1'b0;
		wr_idle_res = 1'b0;
		wr_tick_res = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = ady_q;
		div_req.divisor = step_total_q;
		unique case (state_q)
			ddlc_pkg::ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				load_seg = acc_start;
				div_req.start = acc_start && (steps != '0);
				div_req.dividend = adx;
				div_req.divisor = steps;
				adv_pos = acc_tick && active_q;
				wr_idle_res = acc_tick && !active_q;
			end
			ddlc_pkg::ST_DIV_X: begin
				ld_inc_x = div_stat.done;
				div_req.start = div_stat.done;
			end
			ddlc_pkg::ST_DIV_Y: begin
				ld_inc_y = div_stat.done;
			end
			ddlc_pkg::ST_TICK: begin
				wr_tick_res = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	ddlc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign quo_pos = $signed({1'b0, quotient});
	assign quo_neg = -quo_pos;

	assign step_next = step_number_q + 1'b1;
	assign last_step = (step_next >= step_total_q);

	ddlc_map u_map (
		.pos_x     (pos_x_q),
		.pos_y     (pos_y_q),
		.odd_step  (step_number_q[0]),
		.last_step (last_step),
		.cfg       (cfg_q),
		.result    (tick_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddlc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Segment state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			step_total_q <= '0;
			step_number_q <= '0;
			active_q <= 1'b0;
		end else begin
			if (load_seg) begin
				pos_x_q <= {in_data.x_start, {F{1'b0}}};
				pos_y_q <= {in_data.y_start, {F{1'b0}}};
				inc_x_q <= '0;
				inc_y_q <= '0;
				step_total_q <= steps;
				step_number_q <= '0;
				active_q <= (steps != '0);
			end
			if (ld_inc_x) begin
				inc_x_q <= neg_x_q ? quo_neg : quo_pos;
			end
			if (ld_inc_y) begin
				inc_y_q <= neg_y_q ? quo_neg : quo_pos;
			end
			if (adv_pos) begin
				pos_x_q <= pos_x_q + {{(P-I){inc_x_q[I-1]}}, inc_x_q};
				pos_y_q <= pos_y_q + {{(P-I){inc_y_q[I-1]}}, inc_y_q};
			end
			if (wr_tick_res) begin
				step_number_q <= step_next;
				if (last_step) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_seg) begin
			ady_q <= ady;
			neg_x_q <= dx[C];
			neg_y_q <= dy[C];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_idle_res || wr_tick_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_tick_res) begin
			out_q <= tick_res;
		end else if (wr_idle_res) begin
			out_q <= '{pixel_valid: 1'b0, pixel_x: '0, pixel_y: '0, done_res: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ddlc_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ddlc_pkg::CFG_ORIGIN_X:   cfg_q.origin_x <= cfg_data;
				ddlc_pkg::CFG_ORIGIN_Y:   cfg_q.origin_y <= cfg_data;
				ddlc_pkg::CFG_CLIP_X_MIN: cfg_q.clip_x_min <= cfg_data;
				ddlc_pkg::CFG_CLIP_X_MAX: cfg_q.clip_x_max <= cfg_data;
				ddlc_pkg::CFG_CLIP_Y_MIN: cfg_q.clip_y_min <= cfg_data;
				ddlc_pkg::CFG_CLIP_Y_MAX: cfg_q.clip_y_max <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A transaction is only taken in the idle state.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ddlc_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while the sequencer is busy");

	// While dividing, the divider is running or has just finished.
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ddlc_pkg::ST_DIV_X) || (state_q == ddlc_pkg::ST_DIV_Y))
		|-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// The tick result always finds the result register free.
	a_tick_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddlc_pkg::ST_TICK) |-> !out_valid_q)
		else $error("tick result would overwrite a pending result");

	// An active segment still has steps to go.
	a_steps_left: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_number_q < step_total_q))
		else $error("active segment has no steps left");

	// A tick on an active segment passes through ST_TICK and then produces its result.
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_tick && active_q) |=> (state_q == ddlc_pkg::ST_TICK) ##1 out_valid_q)
		else $error("tick result not delivered on time");

endmodule
